// File: hdl/rbo_pkg.sv
// Shared types and constants for the border overlay blender.
// No dependencies; rbo_colour_stage and the top level import this package.
`timescale 1ns / 1ps
`default_nettype none
package rbo_pkg;

	localparam int FRAME_WIDTH_DEF  = 592;
	localparam int FRAME_HEIGHT_DEF = 480;
	localparam int MAX_RUN_DEF      = 64;

	localparam logic [7:0]  WEIGHT_FULL     = 8'd128;
	localparam logic [11:0] ROW_PITCH_RESET = 12'd592;

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_LOAD  = 2'd1;
	localparam logic [1:0] OP_RUN   = 2'd2;

	localparam int APB_ADDR_W = 4;
	localparam logic [1:0] REG_WINDOW_RGB   = 2'd0;
	localparam logic [1:0] REG_PIXEL_FORMAT = 2'd1;
	localparam logic [1:0] REG_ROW_PITCH    = 2'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic [8:0]  line_index;
		logic [31:0] line_color;
		logic [7:0]  run_weight;
		logic [6:0]  run_length;
	} mask_req_t;

	typedef struct packed {
		logic [9:0]  pixel_x;
		logic [8:0]  pixel_y;
		logic [20:0] pixel_address;
		logic [23:0] pixel_color;
		logic        last;
	} pixel_req_t;

	typedef struct packed {
		logic [23:0] window_rgb;
		logic        pixel_format;
	} blend_cfg_t;

	typedef struct packed {
		logic        en;
		logic [8:0]  idx;
		logic [31:0] data;
	} line_wr_t;

endpackage
`default_nettype wire

// File: hdl/rbo_stream_if.sv
// Valid/ready stream channel carrying one request of type T.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface rbo_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/rbo_colour_stage.sv
// Line colour memory and blend stage: registers the row's border colour and
// forms the registered output colour from it. Depends on rbo_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rbo_colour_stage #(
	parameter int FRAME_HEIGHT = rbo_pkg::FRAME_HEIGHT_DEF
) (
	input  wire logic                clk,
	input  wire rbo_pkg::line_wr_t   wr,
	input  wire logic                adv,
	input  wire logic [8:0]          rd_row,
	input  wire logic [7:0]          weight,
	input  wire rbo_pkg::blend_cfg_t cfg,
	output logic [23:0]              colour_q
);
	import rbo_pkg::*;

	localparam int IDX_W = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;

	logic [31:0] line_mem [FRAME_HEIGHT];
	logic [31:0] word_s1;
	logic [7:0]  weight_s1;

	logic [7:0]  lr, lg, lb, wr8, wg8, wb8, r, g, b;
	logic [23:0] colour_d;

	function automatic logic [7:0] mix(input logic [7:0] win, input logic [7:0] line,
			input logic [7:0] w);
		logic [15:0] a, c;
		logic [14:0] s;
		a = 16'(win) * 16'(w);
		c = 16'(line) * 16'(WEIGHT_FULL - w);
		s = 15'(a + c);
		return s[14:7];
	endfunction

	always_ff @(posedge clk) begin
		if (wr.en) begin
			line_mem[wr.idx[IDX_W-1:0]] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			word_s1   <= line_mem[rd_row[IDX_W-1:0]];
			weight_s1 <= weight;
			colour_q  <= colour_d;
		end
	end

	always_comb begin
		wr8 = cfg.window_rgb[23:16];
		wg8 = cfg.window_rgb[15:8];
		wb8 = cfg.window_rgb[7:0];
		if (cfg.pixel_format) begin
			lr = {word_s1[31:27], 3'b000};
			lg = {word_s1[26:21], 2'b00};
			lb = {word_s1[20:16], 3'b000};
		end else begin
			lr = word_s1[23:16];
			lg = word_s1[15:8];
			lb = word_s1[7:0];
		end
		if (weight_s1 < WEIGHT_FULL) begin
			r = mix(wr8, lr, weight_s1);
			g = mix(wg8, lg, weight_s1);
			b = mix(wb8, lb, weight_s1);
		end else begin
			r = wr8;
			g = wg8;
			b = wb8;
		end
		if (cfg.pixel_format) begin
			colour_d = {8'h00, r[7:3], g[7:2], b[7:3]};
		end else begin
			colour_d = {r, g, b};
		end
	end

endmodule
`default_nettype wire

// File: hdl/rle_border_overlay_blend.sv
// Top level of the run-length border overlay blender: APB registers, run
// sequencer and output register. Depends on rbo_pkg, rbo_stream_if and
// rbo_colour_stage.
//
//   channel  dir  payload      note
//   mask     in   mask_req_t   start, line colour load, mask run
//   pixel    out  pixel_req_t  one request per written pixel
//   apb      in   registers    window_rgb, pixel_format, row_pitch
//
// A start or load request is taken while the sequencer is idle. A run of n
// pixels holds the sequencer busy for n pixels (n capped at MAX_RUN, cut
// short at frame end), one pixel per cycle unless pixel stalls, through the
// line colour memory read register and the blend register, where results leave.
// A stall on pixel freezes the whole pipe; no memory clearing after reset.
`timescale 1ns / 1ps
`default_nettype none
module rle_border_overlay_blend #(
	parameter int FRAME_WIDTH  = rbo_pkg::FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT = rbo_pkg::FRAME_HEIGHT_DEF,
	parameter int MAX_RUN      = rbo_pkg::MAX_RUN_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	rbo_stream_if.sink                           mask,
	rbo_stream_if.source                         pixel,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [rbo_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [31:0]                     pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready
);
	import rbo_pkg::*;

	localparam int RUN_W = $clog2(MAX_RUN + 1);

	mask_req_t  req;
	pixel_req_t res;

	logic [23:0] window_rgb_q;
	logic        pixel_format_q;
	logic [11:0] row_pitch_q;
	logic [1:0]  reg_idx;

	logic [9:0]       col_q;
	logic [8:0]       row_q;
	logic             done_q;
	logic             busy_q;
	logic [RUN_W-1:0] rem_q;
	logic [7:0]       weight_q;

	logic             valid_s1;
	logic [9:0]       x_s1;
	logic [8:0]       y_s1;
	logic [20:0]      addr_s1;
	logic             last_s1;

	logic             out_valid_q;
	logic [9:0]       x_q;
	logic [8:0]       y_q;
	logic [20:0]      addr_q;
	logic             last_q;
	logic [23:0]      colour_q;

	logic             accept, adv, step, row_end, frame_end, last_pix;
	logic [7:0]       w_sat;
	logic [RUN_W-1:0] len_sat;
	logic [20:0]      addr_d;
	line_wr_t         wr;
	blend_cfg_t       cfg;

	assign req     = mask.data;
	assign reg_idx = paddr[3:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_rgb_q   <= '0;
			pixel_format_q <= 1'b0;
			row_pitch_q    <= ROW_PITCH_RESET;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_WINDOW_RGB:   window_rgb_q   <= pwdata[23:0];
				REG_PIXEL_FORMAT: pixel_format_q <= pwdata[0];
				REG_ROW_PITCH:    row_pitch_q    <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_WINDOW_RGB:   prdata = {8'h00, window_rgb_q};
			REG_PIXEL_FORMAT: prdata = {31'd0, pixel_format_q};
			REG_ROW_PITCH:    prdata = {20'd0, row_pitch_q};
			default:          prdata = '0;
		endcase
	end

	assign mask.ready = !busy_q;
	assign accept     = mask.valid && !busy_q;
	assign adv        = !out_valid_q || pixel.ready;
	assign step       = busy_q && adv;
	assign row_end    = (col_q == 10'(FRAME_WIDTH - 1));
	assign frame_end  = row_end && (row_q == 9'(FRAME_HEIGHT - 1));
	assign last_pix   = (rem_q == RUN_W'(1)) || frame_end;
	assign w_sat      = (req.run_weight > WEIGHT_FULL) ? WEIGHT_FULL : req.run_weight;
	assign len_sat    = (req.run_length > 7'(MAX_RUN)) ? RUN_W'(MAX_RUN)
			: RUN_W'(req.run_length);
	assign addr_d     = 21'(row_q) * 21'(row_pitch_q) + 21'(col_q);

	assign wr.en   = accept && (req.op == OP_LOAD) && (req.line_index < 9'(FRAME_HEIGHT));
	assign wr.idx  = req.line_index;
	assign wr.data = req.line_color;

	assign cfg.window_rgb   = window_rgb_q;
	assign cfg.pixel_format = pixel_format_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			done_q   <= 1'b0;
			busy_q   <= 1'b0;
			rem_q    <= '0;
			weight_q <= '0;
		end else if (accept) begin
			case (req.op)
				OP_START: begin
					col_q  <= '0;
					row_q  <= '0;
					done_q <= 1'b0;
				end
				OP_RUN: begin
					if (!done_q && len_sat != '0) begin
						busy_q   <= 1'b1;
						rem_q    <= len_sat;
						weight_q <= w_sat;
					end
				end
				default: ;
			endcase
		end else if (step) begin
			if (row_end) begin
				col_q <= '0;
				if (frame_end) begin
					done_q <= 1'b1;
				end else begin
					row_q <= row_q + 9'd1;
				end
			end else begin
				col_q <= col_q + 10'd1;
			end
			rem_q <= rem_q - RUN_W'(1);
			if (last_pix) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= busy_q && (weight_q != '0);
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1    <= col_q;
			y_s1    <= row_q;
			addr_s1 <= addr_d;
			last_s1 <= last_pix;
			x_q     <= x_s1;
			y_q     <= y_s1;
			addr_q  <= addr_s1;
			last_q  <= last_s1;
		end
	end

	rbo_colour_stage #(
		.FRAME_HEIGHT(FRAME_HEIGHT)
	) u_colour (
		.clk     (clk),
		.wr      (wr),
		.adv     (adv),
		.rd_row  (row_q),
		.weight  (weight_q),
		.cfg     (cfg),
		.colour_q(colour_q)
	);

	assign res.pixel_x       = x_q;
	assign res.pixel_y       = y_q;
	assign res.pixel_address = addr_q;
	assign res.pixel_color   = colour_q;
	assign res.last          = last_q;

	assign pixel.valid = out_valid_q;
	assign pixel.data  = res;

endmodule
`default_nettype wire
